FILE: src/jdsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsv_pkg: shared types and helpers for the Jalali date string validator
// Character codes, calendar limits, parser state type and small functions
// used by the parser and the result stage.
// ----------------------------------------------------------------------------
package jdsv_pkg;

  localparam int unsigned YEAR_WIDTH_DEF = 16;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [6:0]  FIELD_MAX   = 7'd99;
  localparam logic [5:0]  LEAP_CYCLE  = 6'd33;
  localparam logic [6:0]  MONTH_LAST  = 7'd12;
  localparam logic [6:0]  MONTH_SHORT = 7'd7;
  localparam logic [6:0]  DAYS_LONG   = 7'd31;
  localparam logic [6:0]  DAYS_MID    = 7'd30;
  localparam logic [6:0]  DAYS_SHORT  = 7'd29;
  localparam logic [32:0] YEAR_OUT_MAX = 33'd65535;

  localparam logic [1:0] SLASH_DAY   = 2'd0;
  localparam logic [1:0] SLASH_MONTH = 2'd1;
  localparam logic [1:0] SLASH_YEAR  = 2'd2;
  localparam logic [1:0] SLASH_EXTRA = 2'd3;

  // Parser control and short fields; the year accumulator is kept apart
  // because its width follows a module parameter.
  typedef struct packed {
    logic [1:0] slash_seen;
    logic       prev_slash;
    logic       at_start;
    logic       bad_flag;
    logic [6:0] day_acc;
    logic [6:0] month_acc;
    logic [5:0] year_residue;
  } jdsv_state_t;

  localparam jdsv_state_t STATE_START = '{
    slash_seen:   SLASH_DAY,
    prev_slash:   1'b0,
    at_start:     1'b1,
    bad_flag:     1'b0,
    day_acc:      7'd0,
    month_acc:    7'd0,
    year_residue: 6'd0
  };

  // acc * 10 + digit, clipped at 99.
  function automatic logic [6:0] sat99(input logic [6:0] acc, input logic [3:0] dig);
    logic [10:0] v;
    v = 11'(acc) * 11'd10 + 11'(dig);
    return (v > 11'(FIELD_MAX)) ? FIELD_MAX : v[6:0];
  endfunction

  // (res * 10 + digit) mod 33 for res below 33. The quotient comes from a
  // multiply by 497 / 2^14, which is exact for values below 330.
  function automatic logic [5:0] mod33_step(input logic [5:0] res, input logic [3:0] dig);
    logic [8:0]  v;
    logic [17:0] prod;
    logic [3:0]  q;
    logic [8:0]  r;
    v    = 9'(res) * 9'd10 + 9'(dig);
    prod = 18'(v) * 18'd497;
    q    = prod[17:14];
    r    = v - 9'(q) * 9'(LEAP_CYCLE);
    return r[5:0];
  endfunction

  function automatic logic is_leap(input logic [5:0] r);
    logic leap;
    unique case (r)
      6'd1, 6'd5, 6'd9, 6'd13, 6'd17, 6'd22, 6'd26, 6'd30: leap = 1'b1;
      default: leap = 1'b0;
    endcase
    return leap;
  endfunction

  function automatic logic [6:0] month_days(input logic [6:0] m, input logic leap);
    logic [6:0] d;
    priority if (m < MONTH_SHORT) begin
      d = DAYS_LONG;
    end else if (m < MONTH_LAST) begin
      d = DAYS_MID;
    end else if (m == MONTH_LAST) begin
      d = leap ? DAYS_MID : DAYS_SHORT;
    end else begin
      d = 7'd0;
    end
    return d;
  endfunction

endpackage

FILE: src/jdsv_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsv_parser: per-character parser state for the date validator
// Holds slash count, error flag and field accumulators, and presents the
// state as it stands after the character being accepted.
// ----------------------------------------------------------------------------
module jdsv_parser
  import jdsv_pkg::*;
#(
  parameter int unsigned YEAR_WIDTH = YEAR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            char_code,
  input  logic                  last_char,
  output jdsv_state_t           upd_state,
  output logic [YEAR_WIDTH-1:0] upd_year
);

  jdsv_state_t           state_r;
  logic [YEAR_WIDTH-1:0] year_r;

  logic                  is_slash;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [YEAR_WIDTH+3:0] year_mul;

  assign is_slash = (char_code == CHAR_SLASH);
  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign digit    = 4'(char_code - CHAR_ZERO);
  assign year_mul = (YEAR_WIDTH+4)'(year_r) * (YEAR_WIDTH+4)'(10) + (YEAR_WIDTH+4)'(digit);

  always_comb begin
    upd_state = state_r;
    upd_year  = year_r;
    if (is_slash) begin
      if (state_r.at_start || state_r.prev_slash || last_char) begin
        upd_state.bad_flag = 1'b1;
      end
      if (state_r.slash_seen != SLASH_EXTRA) begin
        upd_state.slash_seen = state_r.slash_seen + 2'd1;
      end
      upd_state.prev_slash = 1'b1;
    end else if (is_digit) begin
      unique case (state_r.slash_seen)
        SLASH_DAY:   upd_state.day_acc   = sat99(state_r.day_acc, digit);
        SLASH_MONTH: upd_state.month_acc = sat99(state_r.month_acc, digit);
        SLASH_YEAR: begin
          // Any bit above the year width means the field overflowed.
          if (year_mul[YEAR_WIDTH+3:YEAR_WIDTH] != 4'd0) begin
            upd_year           = '1;
            upd_state.bad_flag = 1'b1;
          end else begin
            upd_year = year_mul[YEAR_WIDTH-1:0];
          end
          upd_state.year_residue = mod33_step(state_r.year_residue, digit);
        end
        default: ;
      endcase
      upd_state.prev_slash = 1'b0;
    end else begin
      upd_state.bad_flag   = 1'b1;
      upd_state.prev_slash = 1'b0;
    end
    upd_state.at_start = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_START;
      year_r  <= '0;
    end else if (accept) begin
      if (last_char) begin
        state_r <= STATE_START;
        year_r  <= '0;
      end else begin
        state_r <= upd_state;
        year_r  <= upd_year;
      end
    end
  end

endmodule

FILE: src/jalali_date_string_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jalali_date_string_validator: day/month/year Solar Hijri date checker
// Parses a date string one character per transaction and, on the last
// character, reports validity, the leap flag and the parsed fields.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata fields (low bit up)               | Side band
//  --------+-----------+-----------------------------------------+-----------
//  in_     | slave     | char_code[7:0]                          | tlast = last_char
//  out_    | master    | date_ok, leap_year, day_value[6:0],     | none
//          |           | month_value[6:0], year_value[15:0]      |
//
// One character is accepted per cycle while in_tready is high. The parser
// state and the result for a last character are both registered at the
// accept edge, in the parser state and the output register.
// The single output register sets the stall behavior: in_tready is low only
// while a result is held and out_tready is low.
// Reset (rst_n low, synchronous) returns the parser to the start of a string
// and empties the output register.
// Characters that are not the last one produce no result transaction.
// ----------------------------------------------------------------------------
module jalali_date_string_validator
  import jdsv_pkg::*;
#(
  parameter int unsigned YEAR_WIDTH = YEAR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [0] date_ok, [1] leap_year, [8:2] day_value,
                                  // [15:9] month_value, [31:16] year_value
);

  logic                  in_accept;
  jdsv_state_t           upd_state;
  logic [YEAR_WIDTH-1:0] upd_year;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  logic        leap;
  logic        month_ok;
  logic        day_ok;
  logic        date_ok;
  logic [32:0] year_ext;
  logic [15:0] year_out;

  // The output register frees up in the same cycle it is drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  jdsv_parser #(
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .char_code (in_tdata),
    .last_char (in_tlast),
    .upd_state (upd_state),
    .upd_year  (upd_year)
  );

  // Final judgement works on the state as it stands after the last character.
  assign leap     = is_leap(upd_state.year_residue);
  assign month_ok = (upd_state.month_acc != 7'd0) && (upd_state.month_acc <= MONTH_LAST);
  assign day_ok   = (upd_state.day_acc != 7'd0) &&
                    (upd_state.day_acc <= month_days(upd_state.month_acc, leap));
  assign date_ok  = !upd_state.bad_flag && (upd_state.slash_seen == SLASH_YEAR) &&
                    month_ok && day_ok;

  // The reported year is clipped to 16 bits whatever the accumulator width.
  assign year_ext = 33'(upd_year);
  assign year_out = (year_ext > YEAR_OUT_MAX) ? YEAR_OUT_MAX[15:0] : year_ext[15:0];

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (in_accept && in_tlast) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {year_out, upd_state.month_acc, upd_state.day_acc, leap, date_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/jdsv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsv_checker: port-level checks for the date validator
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module jdsv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A held result blocks the input, otherwise the input is open.
  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow the output register state");

  // A last character always yields a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("last character did not produce a result");

  // Other characters never create a result.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> !out_tvalid)
    else $error("result appeared without a last character");

  // A valid date has a month from 1 to 12 and a day from 1 to 31.
  a_ok_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      (out_tdata[15:9] != 7'd0) && (out_tdata[15:9] <= 7'd12) &&
      (out_tdata[8:2] != 7'd0) && (out_tdata[8:2] <= 7'd31))
    else $error("date reported valid with fields out of range");

  // A stalled result holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind jalali_date_string_validator jdsv_checker u_jdsv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
